// ----- hw/rtl/tdt_pkg.sv -----
// tdt_pkg: constants, types, cell address helper and triangle length helper for the triangular distance table
// no dependencies
`default_nettype none
package tdt_pkg;
   localparam int MaxNodes  = 64;
   localparam int DistWidth = 16;
   localparam int CellCount = MaxNodes * (MaxNodes + 1) / 2;
   localparam int NodeW     = 6;
   localparam int CountW    = 7;
   localparam int AddrW     = $clog2(CellCount);

   localparam logic [DistWidth-1:0] Unreach = {DistWidth{1'b1}};
   localparam logic [DistWidth-1:0] SatCap  = Unreach - 1'b1;

   localparam logic [2:0] ActWrite  = 3'd0;
   localparam logic [2:0] ActRead   = 3'd1;
   localparam logic [2:0] ActLink   = 3'd2;
   localparam logic [2:0] ActRelay  = 3'd3;
   localparam logic [2:0] ActResize = 3'd4;

   typedef struct packed {
      logic [2:0]  action;
      logic [5:0]  first_node;
      logic [5:0]  second_node;
      logic [15:0] entry_value;
      logic [15:0] extra_cost;
      logic [6:0]  new_count;
   } req_type;

   typedef struct packed {
      logic [15:0] read_value;
      logic        index_error;
   } rsp_type;

   // classified work handed from front to back
   typedef struct packed {
      logic [2:0]           action;
      logic                 err;
      logic [NodeW-1:0]     a;
      logic [NodeW-1:0]     b;
      logic [DistWidth-1:0] val;
      logic [15:0]          extra;
      logic [CountW-1:0]    cnt;
   } job_type;

   function automatic logic [AddrW-1:0] cell_of(input logic [NodeW-1:0] x,
                                                input logic [NodeW-1:0] y);
      logic [NodeW-1:0] lo;
      logic [NodeW-1:0] hi;
      logic [2*NodeW:0] p;
      lo = (x < y) ? x : y;
      hi = (x < y) ? y : x;
      // hi*(hi+1)/2 as (hi*hi + hi) >> 1
      p  = ({{(NodeW+1){1'b0}}, hi} * {{(NodeW+1){1'b0}}, hi}) + {{(NodeW+1){1'b0}}, hi};
      p  = (p >> 1) + {{(NodeW+1){1'b0}}, lo};
      return p[AddrW-1:0];
   endfunction

   function automatic logic [AddrW:0] tri_len(input logic [CountW-1:0] c);
      logic [2*CountW-1:0] p;
      p = ({{CountW{1'b0}}, c} * {{CountW{1'b0}}, c}) + {{CountW{1'b0}}, c};
      return p[AddrW+1:1];
   endfunction
endpackage
`default_nettype wire

// ----- hw/rtl/tdt_if.sv -----
// tdt_if: valid/ready channels for requests and responses, each carrying one payload
// depends on tdt_pkg
`default_nettype none
interface tdt_req_if (input wire logic clock);
   logic              valid;
   logic              ready;
   tdt_pkg::req_type  data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface tdt_rsp_if (input wire logic clock);
   logic              valid;
   logic              ready;
   tdt_pkg::rsp_type  data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/tdt_front.sv -----
// tdt_front: accepts request beats, checks indexes, queues jobs for the back end
// depends on tdt_pkg, tdt_if
`default_nettype none
module tdt_front (
   input  wire logic               clock,
   input  wire logic               reset,
   tdt_req_if.sink                 req,
   input  wire logic [6:0]         count,
   output tdt_pkg::job_type        job,
   output logic                    job_valid,
   input  wire logic               job_take
);
   // two-entry queue
   tdt_pkg::job_type q_ff [2];
   tdt_pkg::job_type q_in;
   tdt_pkg::job_type head;
   logic [1:0] fill_ff, fill_in;
   logic       push, pop;
   logic       ok;

   assign head = q_ff[0];

   // index check at hand-off, so a resize still ahead in the queue is already applied
   assign ok = ({1'b0, head.a} < count) && ({1'b0, head.b} < count);

   assign req.ready = (fill_ff != 2'd2);
   assign push      = req.valid && req.ready;
   assign job_valid = (fill_ff != 2'd0);
   assign pop       = job_valid && job_take;

   always_comb begin
      job = head;
      case (head.action)
         tdt_pkg::ActWrite, tdt_pkg::ActRead, tdt_pkg::ActLink, tdt_pkg::ActRelay:
            job.err = !ok;
         default: job.err = head.err;
      endcase
   end

   always_comb begin
      q_in.action = req.data.action;
      q_in.a      = req.data.first_node;
      q_in.b      = req.data.second_node;
      q_in.val    = req.data.entry_value;
      q_in.extra  = req.data.extra_cost;
      q_in.cnt    = req.data.new_count;
      case (req.data.action)
         tdt_pkg::ActResize: q_in.err = (req.data.new_count > 7'(tdt_pkg::MaxNodes));
         default: q_in.err = 1'b0;
      endcase
      fill_in = fill_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) fill_ff <= 2'd0;
      else fill_ff <= fill_in;
      if (pop) q_ff[0] <= (push && fill_ff == 2'd1) ? q_in : q_ff[1];
      else if (push && fill_ff == 2'd0) q_ff[0] <= q_in;
      if (push && fill_ff == 2'd1 && !pop) q_ff[1] <= q_in;
   end
endmodule
`default_nettype wire

// ----- hw/rtl/tdt_back.sv -----
// tdt_back: sequencer that walks the distance memory for each job
// depends on tdt_pkg, tdt_if
`default_nettype none
module tdt_back (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire tdt_pkg::job_type   job,
   input  wire logic               job_valid,
   output logic                    job_take,
   output logic [6:0]              count,
   tdt_rsp_if.source               rsp
);
   typedef enum logic [8:0] {
      S_IDLE  = 9'b000000001,
      S_RD0   = 9'b000000010,
      S_W0    = 9'b000000100,
      S_RD1   = 9'b000001000,
      S_RDX   = 9'b000010000,
      S_CMP   = 9'b000100000,
      S_FILL  = 9'b001000000,
      S_READ  = 9'b010000000,
      S_OUT   = 9'b100000000
   } state_type;

   localparam int DW = tdt_pkg::DistWidth;
   localparam int AW = tdt_pkg::AddrW;

   logic [DW-1:0] mem [tdt_pkg::CellCount];
   logic [DW-1:0] rdata_ff;
   logic [AW-1:0] raddr;
   logic          wen;
   logic [AW-1:0] waddr;
   logic [DW-1:0] wdata;

   state_type          state_ff, state_in;
   tdt_pkg::job_type   j_ff, j_in;
   logic [6:0]         count_ff, count_in;
   logic [6:0]         i0_ff, i0_in, i1_ff, i1_in;
   logic [DW-1:0]      d0_ff, d0_in, d1_ff, d1_in;
   logic [AW:0]        p_ff, p_in;
   tdt_pkg::rsp_type   out_ff, out_in;
   logic               out_v_ff, out_v_in;
   logic [DW+17:0]     sum;
   logic [DW-1:0]      cand;
   logic [5:0]         i0n, i1n;

   assign i0n = i0_ff[5:0];
   assign i1n = i1_ff[5:0];
   assign count = count_ff;
   assign rsp.valid = out_v_ff;
   assign rsp.data = out_ff;
   assign job_take = (state_ff == S_IDLE) && !out_v_ff;

   // candidate from two stored distances, plus one and the link cost for add link, saturated at SatCap
   always_comb begin
      if (j_ff.action == tdt_pkg::ActLink)
         sum = {18'd0, d0_ff} + {18'd0, d1_ff} + {{(DW+2){1'b0}}, j_ff.extra} + 1'b1;
      else
         sum = {18'd0, d0_ff} + {18'd0, d1_ff};
      cand = (sum > {18'd0, tdt_pkg::SatCap}) ? tdt_pkg::SatCap : sum[DW-1:0];
   end

   always_comb begin
      state_in = state_ff; j_in = j_ff; count_in = count_ff;
      i0_in = i0_ff; i1_in = i1_ff; d0_in = d0_ff; d1_in = d1_ff; p_in = p_ff;
      out_in = out_ff; out_v_in = out_v_ff && !rsp.ready;
      raddr = '0; wen = 1'b0; waddr = '0; wdata = '0;
      case (state_ff)
         S_IDLE: begin
            if (job_valid && !out_v_ff) begin
               j_in = job;
               out_in = '0;
               out_in.index_error = job.err;
               i0_in = '0; i1_in = '0;
               if (job.err) state_in = S_OUT;
               else begin
                  case (job.action)
                     tdt_pkg::ActWrite: begin
                        wen = 1'b1; waddr = tdt_pkg::cell_of(job.a, job.b);
                        wdata = job.val; state_in = S_OUT;
                     end
                     tdt_pkg::ActRead: begin
                        raddr = tdt_pkg::cell_of(job.a, job.b); state_in = S_READ;
                     end
                     tdt_pkg::ActLink: state_in = (count_ff == 7'd0) ? S_OUT : S_RD0;
                     tdt_pkg::ActRelay: begin
                        raddr = tdt_pkg::cell_of(job.a, job.b); state_in = S_W0;
                     end
                     tdt_pkg::ActResize: begin
                        p_in = tdt_pkg::tri_len(count_ff); state_in = S_FILL;
                     end
                     default: state_in = S_OUT;
                  endcase
               end
            end
         end
         S_READ: begin
            out_in.read_value = rdata_ff; state_in = S_OUT;
         end
         S_RD0: begin
            raddr = tdt_pkg::cell_of(i0n, j_ff.a); state_in = S_W0;
         end
         S_W0: begin
            d0_in = rdata_ff; i1_in = '0;
            if (rdata_ff == tdt_pkg::Unreach) begin
               if (j_ff.action == tdt_pkg::ActLink && i0_ff + 7'd1 < count_ff) begin
                  i0_in = i0_ff + 7'd1; state_in = S_RD0;
               end else state_in = S_OUT;
            end else state_in = S_RD1;
         end
         S_RD1: begin
            raddr = tdt_pkg::cell_of(i1n, j_ff.b); state_in = S_RDX;
         end
         S_RDX: begin
            d1_in = rdata_ff;
            raddr = (j_ff.action == tdt_pkg::ActLink) ? tdt_pkg::cell_of(i0n, i1n)
                                                      : tdt_pkg::cell_of(j_ff.a, i1n);
            state_in = S_CMP;
         end
         S_CMP: begin
            // d1 unreachable skips the pair
            if (d1_ff != tdt_pkg::Unreach && cand < rdata_ff) begin
               wen = 1'b1; wdata = cand;
               waddr = (j_ff.action == tdt_pkg::ActLink) ? tdt_pkg::cell_of(i0n, i1n)
                                                         : tdt_pkg::cell_of(j_ff.a, i1n);
            end
            if (i1_ff + 7'd1 < count_ff) begin
               i1_in = i1_ff + 7'd1; state_in = S_RD1;
            end else if (j_ff.action == tdt_pkg::ActLink && i0_ff + 7'd1 < count_ff) begin
               i0_in = i0_ff + 7'd1; state_in = S_RD0;
            end else state_in = S_OUT;
         end
         S_FILL: begin
            if (p_ff < tdt_pkg::tri_len(j_ff.cnt)) begin
               wen = 1'b1; waddr = p_ff[AW-1:0]; wdata = j_ff.val;
               p_in = p_ff + 1'b1;
            end else begin
               count_in = j_ff.cnt; state_in = S_OUT;
            end
         end
         S_OUT: begin
            out_v_in = 1'b1; state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; count_ff <= '0; out_v_ff <= 1'b0;
      end else begin
         state_ff <= state_in; count_ff <= count_in; out_v_ff <= out_v_in;
      end
      j_ff <= j_in; i0_ff <= i0_in; i1_ff <= i1_in; d0_ff <= d0_in; d1_ff <= d1_in;
      p_ff <= p_in; out_ff <= out_in;
   end

   always_ff @(posedge clock) begin
      if (wen) mem[waddr] <= wdata;
      rdata_ff <= mem[raddr];
   end
endmodule
`default_nettype wire

// ----- hw/rtl/triangular_distance_table_unit.sv -----
// triangular distance table unit: write, read, add link, relay and resize on a
// symmetric distance table. a two-beat queue sits ahead of a back end that runs one
// action at a time through the distance memory, which has a read port and a write port;
// the next action starts once the response beat is taken.
// synchronous reset clears node count and handshake state; memory contents undefined.
`default_nettype none
module triangular_distance_table_unit (
   input  wire logic clock,
   input  wire logic reset,
   tdt_req_if.sink   req,
   tdt_rsp_if.source rsp
);
   tdt_pkg::job_type job;
   logic             job_valid, job_take;
   logic [6:0]       count;

   tdt_front u_front (.clock(clock), .reset(reset), .req(req), .count(count),
                      .job(job), .job_valid(job_valid), .job_take(job_take));
   tdt_back  u_back  (.clock(clock), .reset(reset), .job(job), .job_valid(job_valid),
                      .job_take(job_take), .count(count), .rsp(rsp));
endmodule
`default_nettype wire

// ----- dv/tdt_tb_pkg.sv -----
// tdt_tb_pkg: distance table predictor used by the testbench
// depends on tdt_pkg
package tdt_tb_pkg;
   import tdt_pkg::*;

   typedef struct {
      logic [CountW-1:0]    count;
      logic [DistWidth-1:0] cells [CellCount];
   } table_state_t;

   function automatic int cell_pos(int x, int y);
      int lo;
      int hi;
      lo = (x < y) ? x : y;
      hi = (x < y) ? y : x;
      return hi * (hi + 1) / 2 + lo;
   endfunction

   function automatic logic [DistWidth-1:0] sat_add(longint s);
      return (s > longint'(SatCap)) ? SatCap : s[DistWidth-1:0];
   endfunction

   // apply one action to the table copy and return the expected response
   function automatic rsp_type predict_action(ref table_state_t st, input req_type r);
      rsp_type o;
      logic [DistWidth-1:0] d0;
      logic [DistWidth-1:0] d1;
      logic [DistWidth-1:0] cand;
      int n;
      bit ok;
      o = '0;
      n = st.count;
      ok = (r.first_node < n) && (r.second_node < n);
      case (r.action)
         ActWrite: begin
            if (ok) st.cells[cell_pos(r.first_node, r.second_node)] = r.entry_value;
            else o.index_error = 1'b1;
         end
         ActRead: begin
            if (ok) o.read_value = st.cells[cell_pos(r.first_node, r.second_node)];
            else o.index_error = 1'b1;
         end
         ActLink: begin
            if (!ok) o.index_error = 1'b1;
            else for (int i0 = 0; i0 < n; i0++) begin
               d0 = st.cells[cell_pos(i0, r.first_node)];
               if (d0 == Unreach) continue;
               for (int i1 = 0; i1 < n; i1++) begin
                  d1 = st.cells[cell_pos(i1, r.second_node)];
                  if (d1 == Unreach) continue;
                  cand = sat_add(longint'(d0) + d1 + 1 + r.extra_cost);
                  if (cand < st.cells[cell_pos(i0, i1)]) st.cells[cell_pos(i0, i1)] = cand;
               end
            end
         end
         ActRelay: begin
            if (!ok) o.index_error = 1'b1;
            else begin
               d0 = st.cells[cell_pos(r.first_node, r.second_node)];
               if (d0 != Unreach) for (int i1 = 0; i1 < n; i1++) begin
                  d1 = st.cells[cell_pos(i1, r.second_node)];
                  if (d1 == Unreach) continue;
                  cand = sat_add(longint'(d0) + d1);
                  if (cand < st.cells[cell_pos(r.first_node, i1)])
                     st.cells[cell_pos(r.first_node, i1)] = cand;
               end
            end
         end
         ActResize: begin
            if (r.new_count > MaxNodes) o.index_error = 1'b1;
            else begin
               for (int p = n * (n + 1) / 2; p < r.new_count * (r.new_count + 1) / 2; p++)
                  st.cells[p] = r.entry_value;
               st.count = r.new_count;
            end
         end
         default: ;
      endcase
      return o;
   endfunction
endpackage

// ----- dv/testbench.sv -----
// testbench: directed table then random actions against the distance table predictor
// depends on tdt_pkg, tdt_if, tdt_tb_pkg and the triangular_distance_table_unit rtl
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import tdt_pkg::*;
   import tdt_tb_pkg::*;

   localparam int StallLimit = 600000;

   typedef struct {
      req_type beat;
      bit      typed;
      rsp_type want;
   } step_row_t;

   logic clock = 1'b0;
   logic reset = 1'b1;
   tdt_req_if req (clock);
   tdt_rsp_if rsp (clock);

   triangular_distance_table_unit u_top (.clock(clock), .reset(reset), .req(req), .rsp(rsp));

   initial begin
      forever #2 clock = ~clock;
   end

   table_state_t dist_copy;
   rsp_type      pending_rsp [$];
   step_row_t    steps [$];
   int  fail_count = 0;
   int  rsp_seen = 0;
   int  idle_cycles = 0;
   int  send_idle_pct = 22;
   int  recv_idle_pct = 22;
   bit  recv_hold = 1'b0;

   function automatic req_type make_req(logic [2:0] act, int x, int y, int v, int e, int c);
      req_type r;
      r.action = act;
      r.first_node = x[5:0];
      r.second_node = y[5:0];
      r.entry_value = v[15:0];
      r.extra_cost = e[15:0];
      r.new_count = c[6:0];
      return r;
   endfunction

   task automatic add_row(req_type r, bit typed = 0, int rd = 0, bit er = 0);
      step_row_t s;
      s.beat = r;
      s.typed = typed;
      s.want.read_value = rd[15:0];
      s.want.index_error = er;
      steps = {steps, s};
   endtask

   // keeps node indexes in range most of the time, with some bad indexes
   function automatic req_type random_req(int n);
      req_type r;
      logic [63:0] raw;
      int pick;
      raw = {$urandom, $urandom};
      r = raw[$bits(req_type)-1:0];
      pick = $urandom_range(0, 99);
      if (pick < 8) r.action = ActResize;
      else if (pick < 11) r.action = 3'($urandom_range(5, 7));
      else r.action = 3'($urandom_range(0, 3));
      if (n > 0 && $urandom_range(0, 9) != 0) begin
         r.first_node = 6'($urandom_range(0, n - 1));
         r.second_node = 6'($urandom_range(0, n - 1));
      end
      if ($urandom_range(0, 3) != 0) r.entry_value = 16'($urandom_range(0, 200));
      if ($urandom_range(0, 5) == 0) r.entry_value = Unreach;
      if ($urandom_range(0, 3) != 0) r.extra_cost = 16'($urandom_range(0, 20));
      if (r.action == ActResize) begin
         if ($urandom_range(0, 19) == 0) r.new_count = 7'($urandom_range(65, 127));
         else if ($urandom_range(0, 9) == 0) r.new_count = 7'd64;
         else r.new_count = 7'($urandom_range(1, 12));
      end
      return r;
   endfunction

   // leaves valid high after the accept; the next call or the caller drops it
   task automatic send_beat(req_type r);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req.valid <= 1'b0;
         @(negedge clock);
      end
      req.valid <= 1'b1;
      req.data <= r;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      @(negedge clock);
   endtask

   // predictor runs on accepted beats
   always @(posedge clock) begin
      if (!reset && req.valid && req.ready) begin
         pending_rsp = {pending_rsp, predict_action(dist_copy, req.data)};
      end
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp.valid && rsp.ready) begin
         rsp_seen++;
         if (pending_rsp.size() == 0) begin
            $display("%0t: response with nothing expected, got %h", $time, rsp.data);
            fail_count++;
         end else begin
            want = pending_rsp.pop_front();
            if (rsp.data.read_value !== want.read_value) begin
               $display("%0t: read_value expected %h actual %h", $time,
                        want.read_value, rsp.data.read_value);
               fail_count++;
            end
            if (rsp.data.index_error !== want.index_error) begin
               $display("%0t: index_error expected %b actual %b", $time,
                        want.index_error, rsp.data.index_error);
               fail_count++;
            end
         end
      end
   end

   // typed expectations for directed rows
   int typed_idx = 0;
   always @(posedge clock) begin
      if (!reset && rsp.valid && rsp.ready && typed_idx < steps.size()) begin
         if (steps[typed_idx].typed && rsp.data !== steps[typed_idx].want) begin
            $display("%0t: directed row %0d expected %h actual %h", $time, typed_idx,
                     steps[typed_idx].want, rsp.data);
            fail_count++;
         end
         typed_idx++;
      end
   end

   always @(negedge clock) begin
      if (recv_hold || reset) rsp.ready <= 1'b0;
      else rsp.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
   end

   always @(posedge clock) begin
      if (reset || (req.valid && req.ready) || (rsp.valid && rsp.ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > StallLimit) begin
         $display("Some tests failed");
         $finish;
      end
   end

   initial begin
      req_type r;
      int sent;
      dist_copy.count = '0;
      foreach (dist_copy.cells[p]) dist_copy.cells[p] = '0;
      req.valid = 1'b0;
      req.data = '0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed table
      add_row(make_req(ActRead, 0, 0, 0, 0, 0), 1, 0, 1);
      add_row(make_req(ActWrite, 0, 0, 5, 0, 0), 1, 0, 1);
      add_row(make_req(ActResize, 0, 0, 0, 0, 65), 1, 0, 1);
      add_row(make_req(ActResize, 0, 0, 16'hffff, 0, 4), 1, 0, 0);
      add_row(make_req(ActRead, 3, 2, 0, 0, 0), 1, 16'hffff, 0);
      add_row(make_req(ActWrite, 0, 0, 0, 0, 0), 1, 0, 0);
      add_row(make_req(ActWrite, 1, 0, 16'hfff0, 0, 0), 1, 0, 0);
      add_row(make_req(ActWrite, 1, 1, 0, 0, 0), 1, 0, 0);
      add_row(make_req(ActLink, 0, 1, 0, 16'hffff, 0), 1, 0, 0);
      add_row(make_req(ActRead, 0, 1, 0, 0, 0));
      add_row(make_req(ActRelay, 2, 0, 0, 0, 0));
      add_row(make_req(ActWrite, 2, 0, 16'hfffd, 0, 0));
      add_row(make_req(ActRelay, 2, 0, 0, 0, 0));
      add_row(make_req(ActRead, 1, 2, 0, 0, 0));
      add_row(make_req(ActLink, 4, 0, 0, 0, 0), 1, 0, 1);
      add_row(make_req(ActRelay, 0, 63, 0, 0, 0), 1, 0, 1);
      add_row(make_req(3'd5, 63, 63, 16'hffff, 16'hffff, 127), 1, 0, 0);
      add_row(make_req(3'd7, 0, 0, 0, 0, 0), 1, 0, 0);
      add_row(make_req(ActResize, 0, 0, 7, 0, 64), 1, 0, 0);
      add_row(make_req(ActRead, 63, 63, 0, 0, 0), 1, 7, 0);
      add_row(make_req(ActResize, 0, 0, 0, 0, 2), 1, 0, 0);
      add_row(make_req(ActResize, 0, 0, 9, 0, 3), 1, 0, 0);
      add_row(make_req(ActRead, 2, 1, 0, 0, 0), 1, 9, 0);
      foreach (steps[i]) send_beat(steps[i].beat);
      req.valid <= 1'b0;

      // sender pauses until everything has drained
      wait (pending_rsp.size() == 0);

      // receiver holds off while requests keep coming
      fork
         begin
            recv_hold = 1'b1;
            repeat (300) @(posedge clock);
            recv_hold = 1'b0;
         end
         for (int i = 0; i < 6; i++) send_beat(random_req(dist_copy.count));
      join

      sent = 0;
      while (sent < 70) begin
         // a quiet stretch with no idling on either side
         if (sent == 25) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         if (sent == 50) begin
            send_idle_pct = 22;
            recv_idle_pct = 22;
         end
         r = random_req(dist_copy.count);
         send_beat(r);
         sent++;
      end
      req.valid <= 1'b0;
      wait (pending_rsp.size() == 0);
      repeat (50) @(posedge clock);
      $display("ran the directed actions and a random stream, %0d responses checked",
               rsp_seen);
      $display("covered all actions, bad indexes, oversized resize and saturating links");
      if (fail_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end
endmodule

// ----- triangular_distance_table_unit.f -----
hw/rtl/tdt_pkg.sv
hw/rtl/tdt_if.sv
hw/rtl/tdt_front.sv
hw/rtl/tdt_back.sv
hw/rtl/triangular_distance_table_unit.sv
dv/tdt_tb_pkg.sv
dv/testbench.sv
